FILE: src/adu_pkg.sv
package adu_pkg;

	localparam int GRID_WIDTH_DEF  = 256;
	localparam int GRID_HEIGHT_DEF = 256;
	localparam int COUNT_BITS_DEF  = 32;

	localparam int CFG_AW = 5;

	typedef enum logic [2:0] {
		REG_COEF_A     = 3'd0,
		REG_COEF_B     = 3'd1,
		REG_COEF_C     = 3'd2,
		REG_COEF_D     = 3'd3,
		REG_PLOT_SCALE = 3'd4,
		REG_OFFSET_X   = 3'd5,
		REG_OFFSET_Y   = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_ITER  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic signed [20:0] coef_a;
		logic signed [20:0] coef_b;
		logic signed [20:0] coef_c;
		logic signed [20:0] coef_d;
		logic [23:0]        plot_scale;
		logic signed [18:0] offset_x;
		logic signed [18:0] offset_y;
	} cfg_t;

	// decoded request handed from front to back
	typedef struct packed {
		cmd_t               cmd;
		logic signed [18:0] start_x;
		logic signed [18:0] start_y;
		logic [7:0]         read_col;
		logic [7:0]         read_row;
		logic               rd_ok;
	} op_t;

	typedef struct packed {
		logic        ok;
		logic [22:0] idx;
	} axis_t;

	localparam logic signed [40:0] TWO_PI_Q32  = 41'sd26986075409;
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [33:0] TWO_PI_Q30  = 34'sd6746518852;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam int CORDIC_STEPS = 24;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0:  r = 34'sd843314856;
			5'd1:  r = 34'sd497837829;
			5'd2:  r = 34'sd263043836;
			5'd3:  r = 34'sd133525158;
			5'd4:  r = 34'sd67021686;
			5'd5:  r = 34'sd33543515;
			5'd6:  r = 34'sd16775850;
			5'd7:  r = 34'sd8388437;
			5'd8:  r = 34'sd4194282;
			5'd9:  r = 34'sd2097149;
			5'd10: r = 34'sd1048575;
			5'd11: r = 34'sd524287;
			5'd12: r = 34'sd262143;
			5'd13: r = 34'sd131071;
			5'd14: r = 34'sd65535;
			5'd15: r = 34'sd32767;
			5'd16: r = 34'sd16383;
			5'd17: r = 34'sd8191;
			5'd18: r = 34'sd4095;
			5'd19: r = 34'sd2047;
			5'd20: r = 34'sd1023;
			5'd21: r = 34'sd511;
			5'd22: r = 34'sd255;
			5'd23: r = 34'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q24 position to cell index, truncating toward zero
	function automatic axis_t axis_map(input logic signed [46:0] v, input logic [12:0] lim);
		axis_t a;
		logic signed [46:0] mag;
		mag = -v;
		if (v < 0) begin
			a.ok  = (mag[46:24] == '0);
			a.idx = '0;
		end else begin
			a.idx = v[46:24];
			a.ok  = (a.idx < {10'd0, lim});
		end
		return a;
	endfunction

endpackage

FILE: src/adu_if.sv
interface adu_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [18:0] start_x;
	logic signed [18:0] start_y;
	logic [7:0]         read_col;
	logic [7:0]         read_row;

	modport source(output valid, command, start_x, start_y, read_col, read_row, input ready);
	modport sink(input valid, command, start_x, start_y, read_col, read_row, output ready);
endinterface

interface adu_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [18:0] new_x;
	logic signed [18:0] new_y;
	logic               hit;
	logic [7:0]         pixel_col;
	logic [7:0]         pixel_row;
	logic [31:0]        cell_count;
	logic [31:0]        max_count;
	logic [47:0]        total_iterations;

	modport source(output valid, new_x, new_y, hit, pixel_col, pixel_row, cell_count,
		max_count, total_iterations, input ready);
	modport sink(input valid, new_x, new_y, hit, pixel_col, pixel_row, cell_count,
		max_count, total_iterations, output ready);
endinterface

FILE: src/adu_front.sv
module adu_front import adu_pkg::*; #(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	adu_req_if.sink   req,
	output op_t       op,
	output logic      op_valid,
	input  logic      op_pop
);

	op_t        fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	op_t        dec;
	logic       push, pop;

	assign req.ready = (cnt_q != 2'd2);
	assign op_valid  = (cnt_q != 2'd0);
	assign op        = fifo_q[rd_q];
	assign push      = req.valid && req.ready;
	assign pop       = op_pop && op_valid;

	always_comb begin
		dec.start_x  = req.start_x;
		dec.start_y  = req.start_y;
		dec.read_col = req.read_col;
		dec.read_row = req.read_row;
		dec.rd_ok    = ({5'd0, req.read_col} < 13'(GRID_WIDTH)) &&
			({5'd0, req.read_row} < 13'(GRID_HEIGHT));
		// all four codes are members of cmd_t; the unused one decodes as CMD_NONE
		dec.cmd      = cmd_t'(req.command);
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

FILE: src/adu_sincos.sv
module adu_sincos import adu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [39:0] angle,
	output logic               done,
	output logic signed [19:0] sin_q16,
	output logic signed [19:0] cos_q16
);

	typedef enum logic [4:0] {
		SC_IDLE = 5'b00001,
		SC_RED  = 5'b00010,
		SC_FOLD = 5'b00100,
		SC_ROT  = 5'b01000,
		SC_OUT  = 5'b10000
	} sc_state_t;

	sc_state_t          state_q;
	logic signed [40:0] r_q;
	logic [1:0]         k_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0]         i_q;
	logic               neg_q;

	logic signed [40:0] step;
	logic signed [33:0] rq, zf, dx, dy, cx;
	logic               negf;

	assign step = TWO_PI_Q32 <<< k_q;
	assign dx   = y_q >>> i_q;
	assign dy   = x_q >>> i_q;
	assign cx   = neg_q ? -x_q : x_q;

	always_comb begin
		rq = 34'(r_q >>> 2);
		if (rq >= PI_Q30) rq = rq - TWO_PI_Q30;
		negf = 1'b0;
		zf   = rq;
		if (rq > HALF_PI_Q30) begin
			zf   = PI_Q30 - rq;
			negf = 1'b1;
		end else if (rq < -HALF_PI_Q30) begin
			zf   = -PI_Q30 - rq;
			negf = 1'b1;
		end
	end

	assign done    = (state_q == SC_OUT);
	assign sin_q16 = 20'((y_q + 34'sd8192) >>> 14);
	assign cos_q16 = 20'((cx + 34'sd8192) >>> 14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			r_q     <= '0;
			k_q     <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			i_q     <= '0;
			neg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				SC_IDLE: if (start) begin
					// bias negatives by 16 turns so the reduction only subtracts
					r_q     <= (angle < 0) ? (41'(angle) + (TWO_PI_Q32 <<< 4)) : 41'(angle);
					k_q     <= 2'd3;
					state_q <= SC_RED;
				end
				SC_RED: begin
					if (r_q >= step) r_q <= r_q - step;
					if (k_q == 2'd0) state_q <= SC_FOLD;
					else k_q <= k_q - 2'd1;
				end
				SC_FOLD: begin
					x_q     <= CORDIC_GAIN;
					y_q     <= '0;
					z_q     <= zf;
					neg_q   <= negf;
					i_q     <= '0;
					state_q <= SC_ROT;
				end
				SC_ROT: begin
					if (z_q >= 0) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - atan_q30(i_q);
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + atan_q30(i_q);
					end
					if (i_q == 5'(CORDIC_STEPS - 1)) state_q <= SC_OUT;
					else i_q <= i_q + 5'd1;
				end
				SC_OUT: state_q <= SC_IDLE;
				default: state_q <= SC_IDLE;
			endcase
		end
	end

endmodule

FILE: src/adu_back.sv
module adu_back import adu_pkg::*; #(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  op_t       op,
	input  logic      op_valid,
	output logic      op_pop,
	adu_rsp_if.source rsp
);

	localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
	localparam int ADDR_W = $clog2(CELLS);

	typedef enum logic [10:0] {
		B_SWEEP = 11'b00000000001,
		B_IDLE  = 11'b00000000010,
		B_MUL   = 11'b00000000100,
		B_CS    = 11'b00000001000,
		B_WAIT  = 11'b00000010000,
		B_PX    = 11'b00000100000,
		B_PY    = 11'b00001000000,
		B_MAP   = 11'b00010000000,
		B_RD    = 11'b00100000000,
		B_UPD   = 11'b01000000000,
		B_EMIT  = 11'b10000000000
	} b_state_t;

	logic [COUNT_BITS-1:0] mem [CELLS];

	b_state_t              state_q;
	cmd_t                  cmd_q;
	logic [ADDR_W-1:0]     sweep_q, addr_q;
	logic signed [18:0]    point_x_q, point_y_q, nx_q;
	logic [COUNT_BITS-1:0] peak_q, cell_q, rdata_q;
	logic [47:0]           iter_q;
	logic [1:0]            phase_q;
	logic signed [39:0]    prod_q;
	logic signed [19:0]    s1_q;
	logic signed [44:0]    ppx_q, ppy_q;
	logic                  hit_q;
	logic [7:0]            col_q, row_q;
	logic                  out_valid_q;

	logic               cs_done;
	logic signed [19:0] cs_sin, cs_cos;
	logic signed [20:0] coef_sel;
	logic signed [18:0] pt_sel;
	logic signed [46:0] vx, vy;
	axis_t              ax, ay;
	logic [COUNT_BITS-1:0] nv;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;

	adu_sincos u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == B_CS),
		.angle   (prod_q),
		.done    (cs_done),
		.sin_q16 (cs_sin),
		.cos_q16 (cs_cos)
	);

	// a*y, b*x, c*x, d*y
	always_comb begin
		case (phase_q)
			2'd0:    begin coef_sel = cfg.coef_a; pt_sel = point_y_q; end
			2'd1:    begin coef_sel = cfg.coef_b; pt_sel = point_x_q; end
			2'd2:    begin coef_sel = cfg.coef_c; pt_sel = point_x_q; end
			default: begin coef_sel = cfg.coef_d; pt_sel = point_y_q; end
		endcase
	end

	assign vx = 47'(ppx_q) + (47'(GRID_WIDTH) <<< 23);
	assign vy = 47'(ppy_q) + (47'(GRID_HEIGHT) <<< 23);
	assign ax = axis_map(vx, 13'(GRID_WIDTH));
	assign ay = axis_map(vy, 13'(GRID_HEIGHT));

	assign nv = (rdata_q == {COUNT_BITS{1'b1}}) ? rdata_q : rdata_q + 1'b1;

	assign mem_we    = (state_q == B_SWEEP) || (state_q == B_UPD && cmd_q == CMD_ITER);
	assign mem_waddr = (state_q == B_SWEEP) ? sweep_q : addr_q;
	assign mem_wdata = (state_q == B_SWEEP) ? '0 : nv;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (state_q == B_RD) rdata_q <= mem[addr_q];
	end

	assign op_pop = (state_q == B_IDLE) && op_valid;

	assign rsp.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_SWEEP;
			cmd_q       <= CMD_NONE;
			sweep_q     <= '0;
			addr_q      <= '0;
			point_x_q   <= '0;
			point_y_q   <= '0;
			nx_q        <= '0;
			peak_q      <= '0;
			cell_q      <= '0;
			iter_q      <= '0;
			phase_q     <= '0;
			prod_q      <= '0;
			s1_q        <= '0;
			ppx_q       <= '0;
			ppy_q       <= '0;
			hit_q       <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
			rsp.new_x      <= '0;
			rsp.new_y      <= '0;
			rsp.hit        <= 1'b0;
			rsp.pixel_col  <= '0;
			rsp.pixel_row  <= '0;
			rsp.cell_count <= '0;
			rsp.max_count        <= '0;
			rsp.total_iterations <= '0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != B_EMIT) out_valid_q <= 1'b0;
			unique case (state_q)
				B_SWEEP: begin
					if (sweep_q == ADDR_W'(CELLS - 1))
						state_q <= (cmd_q == CMD_CLEAR) ? B_EMIT : B_IDLE;
					else
						sweep_q <= sweep_q + 1'b1;
				end
				B_IDLE: if (op_valid) begin
					cmd_q  <= op.cmd;
					hit_q  <= 1'b0;
					col_q  <= '0;
					row_q  <= '0;
					cell_q <= '0;
					unique case (op.cmd)
						CMD_ITER: begin
							phase_q <= 2'd0;
							state_q <= B_MUL;
						end
						CMD_CLEAR: begin
							point_x_q <= op.start_x;
							point_y_q <= op.start_y;
							peak_q    <= '0;
							iter_q    <= '0;
							sweep_q   <= '0;
							state_q   <= B_SWEEP;
						end
						CMD_READ: begin
							col_q   <= op.read_col;
							row_q   <= op.read_row;
							addr_q  <= ADDR_W'(int'(op.read_row) * GRID_WIDTH + int'(op.read_col));
							state_q <= op.rd_ok ? B_RD : B_EMIT;
						end
						default: state_q <= B_EMIT;
					endcase
				end
				B_MUL: begin
					prod_q  <= coef_sel * pt_sel;
					state_q <= B_CS;
				end
				B_CS: state_q <= B_WAIT;
				B_WAIT: if (cs_done) begin
					case (phase_q)
						2'd0, 2'd2: s1_q <= cs_sin;
						2'd1:       nx_q <= 19'(s1_q - cs_cos);
						default: begin
							point_x_q <= nx_q;
							point_y_q <= 19'(s1_q - cs_cos);
						end
					endcase
					if (phase_q == 2'd3) begin
						state_q <= B_PX;
					end else begin
						phase_q <= phase_q + 2'd1;
						state_q <= B_MUL;
					end
				end
				B_PX: begin
					ppx_q   <= (20'(point_x_q) + 20'(cfg.offset_x)) * $signed({1'b0, cfg.plot_scale});
					state_q <= B_PY;
				end
				B_PY: begin
					ppy_q   <= (20'(point_y_q) + 20'(cfg.offset_y)) * $signed({1'b0, cfg.plot_scale});
					state_q <= B_MAP;
				end
				B_MAP: begin
					iter_q <= iter_q + 48'd1;
					if (ax.ok && ay.ok) begin
						hit_q   <= 1'b1;
						col_q   <= ax.idx[7:0];
						row_q   <= ay.idx[7:0];
						addr_q  <= ADDR_W'(int'(ay.idx) * GRID_WIDTH + int'(ax.idx));
						state_q <= B_RD;
					end else begin
						state_q <= B_EMIT;
					end
				end
				B_RD: state_q <= B_UPD;
				B_UPD: begin
					if (cmd_q == CMD_READ) begin
						cell_q <= rdata_q;
					end else begin
						cell_q <= nv;
						if (nv > peak_q) peak_q <= nv;
					end
					state_q <= B_EMIT;
				end
				B_EMIT: if (!out_valid_q || rsp.ready) begin
					out_valid_q    <= 1'b1;
					rsp.new_x      <= point_x_q;
					rsp.new_y      <= point_y_q;
					rsp.hit        <= hit_q;
					rsp.pixel_col  <= col_q;
					rsp.pixel_row  <= row_q;
					rsp.cell_count <= 32'(cell_q);
					rsp.max_count        <= 32'(peak_q);
					rsp.total_iterations <= iter_q;
					state_q        <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

FILE: src/attractor_density_accumulator_unit.sv
// channel   | dir | handshake     | carries
// req       | in  | valid/ready   | command, start_x, start_y, read_col, read_row
// rsp       | out | valid/ready   | new_x, new_y, hit, pixel_col/row, cell/max count, total
// apb       | in  | psel/penable  | coef_a..d, plot_scale, offset_x/y at 4*index
//
// Iterate: four passes through the one shared CORDIC unit (multiply, 4 reduction steps,
//   fold, 24 rotations, round), then two scale multiplies, index map and, when the point
//   lands in the grid, a read-modify-write of the histogram RAM.
// Read: one histogram RAM read, none outside the grid. Clear: zeroes the RAM, one cell per cycle.
// After reset the same sweep runs before any request.
// A two-entry request queue keeps taking requests, until it is full, while the back end works or
//   while a finished response waits in the output register.
module attractor_density_accumulator_unit import adu_pkg::*; #(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	adu_req_if.sink           req,
	adu_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	op_t      op;
	logic     op_valid, op_pop;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);

	// register writes complete in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_a     <= 21'sd93004;
			cfg_q.coef_b     <= -21'sd149693;
			cfg_q.coef_c     <= 21'sd159091;
			cfg_q.coef_d     <= -21'sd142685;
			cfg_q.plot_scale <= 24'd13107;
			cfg_q.offset_x   <= '0;
			cfg_q.offset_y   <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				REG_COEF_A:     cfg_q.coef_a     <= pwdata[20:0];
				REG_COEF_B:     cfg_q.coef_b     <= pwdata[20:0];
				REG_COEF_C:     cfg_q.coef_c     <= pwdata[20:0];
				REG_COEF_D:     cfg_q.coef_d     <= pwdata[20:0];
				REG_PLOT_SCALE: cfg_q.plot_scale <= pwdata[23:0];
				REG_OFFSET_X:   cfg_q.offset_x   <= pwdata[18:0];
				REG_OFFSET_Y:   cfg_q.offset_y   <= pwdata[18:0];
				default: ;
			endcase
		end
	end

	// readback returns the raw register bits, zero extended
	always_comb begin
		unique case (idx)
			REG_COEF_A:     prdata = {11'd0, cfg_q.coef_a};
			REG_COEF_B:     prdata = {11'd0, cfg_q.coef_b};
			REG_COEF_C:     prdata = {11'd0, cfg_q.coef_c};
			REG_COEF_D:     prdata = {11'd0, cfg_q.coef_d};
			REG_PLOT_SCALE: prdata = {8'd0, cfg_q.plot_scale};
			REG_OFFSET_X:   prdata = {13'd0, cfg_q.offset_x};
			REG_OFFSET_Y:   prdata = {13'd0, cfg_q.offset_y};
			default:        prdata = '0;
		endcase
	end

	// front: queue and decode requests
	adu_front #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.op       (op),
		.op_valid (op_valid),
		.op_pop   (op_pop)
	);

	// back: attractor step, pixel map, histogram RAM, response register
	adu_back #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.op       (op),
		.op_valid (op_valid),
		.op_pop   (op_pop),
		.rsp      (rsp)
	);

endmodule

FILE: tb/tb_attractor_density_accumulator_unit.sv
module tb_attractor_density_accumulator_unit;
	import adu_pkg::*;

	// Stall limit: set well above the clear sweep of all 64K cells.
	localparam int STALL_LIMIT = 400000;
	localparam int SETTLE      = 400;
	localparam longint TWO_PI_Q32_L  = 64'sd26986075409;
	localparam longint PI_Q30_L      = 64'sd3373259426;
	localparam longint TWO_PI_Q30_L  = 64'sd6746518852;
	localparam longint HALF_PI_Q30_L = 64'sd1686629713;
	localparam longint GAIN_Q30_L    = 64'sd652032874;
	localparam longint ARCTAN_Q30 [24] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127};

	typedef struct {
		cmd_t               cmd;
		logic signed [18:0] sx;
		logic signed [18:0] sy;
		logic [7:0]         rc;
		logic [7:0]         rr;
	} request_t;

	typedef struct {
		logic [18:0] nx;
		logic [18:0] ny;
		logic        hit;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [31:0] cnt_val;
		logic [31:0] peak;
		logic [47:0] total;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	adu_req_if req_ch();
	adu_rsp_if rsp_ch();

	attractor_density_accumulator_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// shadow of the block's registers and state
	logic signed [20:0] k_a, k_b, k_c, k_d;
	logic [23:0]        k_scale;
	logic signed [18:0] k_offx, k_offy;
	logic signed [18:0] pt_x, pt_y;
	int unsigned        density [int];
	logic [31:0]        peak;
	logic [47:0]        iters;

	request_t pending_q[$];
	outcome_t outcome_q[$];
	int       hit_cells[$];
	int       n_pushed = 0, n_taken = 0, errors = 0, idle_cycles = 0;
	bit       req_took = 0, quiet = 0, hold_req = 0, hold_done = 0;
	int       gap_cnt = 0, stall_cnt = 0, hold_cnt = 0;

	// CORDIC sin/cos of a Q32 angle, rounded to Q16
	function automatic void sin_cos(input longint ang, output longint s, output longint c);
		longint r, x, y, z, dx, dy;
		bit neg;
		r = ang % TWO_PI_Q32_L;
		if (r < 0) r += TWO_PI_Q32_L;
		r = r >>> 2;
		if (r >= PI_Q30_L) r -= TWO_PI_Q30_L;
		neg = 0;
		if (r > HALF_PI_Q30_L) begin
			r = PI_Q30_L - r;
			neg = 1;
		end else if (r < -HALF_PI_Q30_L) begin
			r = -PI_Q30_L - r;
			neg = 1;
		end
		x = GAIN_Q30_L;
		y = 0;
		z = r;
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN_Q30[i];
			end else begin
				x += dx; y -= dy; z += ARCTAN_Q30[i];
			end
		end
		if (neg) x = -x;
		s = (y + 8192) >>> 14;
		c = (x + 8192) >>> 14;
	endfunction

	// Q24 pixel position, truncated toward zero
	function automatic longint pixel_of(input longint p, input longint off, input longint ext);
		longint v;
		v = (p + off) * longint'(k_scale) + (ext << 23);
		return (v >= 0) ? (v >>> 24) : -((-v) >>> 24);
	endfunction

	function automatic outcome_t advance(input request_t r);
		outcome_t o;
		longint s1, c1, s2, c2, nx, ny, ix, iy;
		int key;
		o.hit = 0; o.col = '0; o.row = '0; o.cnt_val = '0;
		case (r.cmd)
			CMD_ITER: begin
				sin_cos(longint'(k_a) * longint'(pt_y), s1, c1);
				sin_cos(longint'(k_b) * longint'(pt_x), s2, c1);
				nx = s1 - c1;
				sin_cos(longint'(k_c) * longint'(pt_x), s1, c2);
				sin_cos(longint'(k_d) * longint'(pt_y), s2, c2);
				ny = s1 - c2;
				pt_x = nx[18:0];
				pt_y = ny[18:0];
				ix = pixel_of(pt_x, k_offx, 256);
				iy = pixel_of(pt_y, k_offy, 256);
				if (ix >= 0 && iy >= 0 && ix < 256 && iy < 256) begin
					key = int'(iy) * 256 + int'(ix);
					if (!density.exists(key)) density[key] = 0;
					if (density[key] != 32'hFFFF_FFFF) density[key]++;
					if (density[key] > peak) peak = density[key];
					o.hit = 1;
					o.col = ix[7:0];
					o.row = iy[7:0];
					o.cnt_val = density[key];
					hit_cells.push_back(key);
				end
				iters++;
			end
			CMD_CLEAR: begin
				density.delete();
				peak = '0;
				iters = '0;
				pt_x = r.sx;
				pt_y = r.sy;
			end
			CMD_READ: begin
				key = int'(r.rr) * 256 + int'(r.rc);
				o.col = r.rc;
				o.row = r.rr;
				o.cnt_val = density.exists(key) ? density[key] : 0;
			end
			default: ;
		endcase
		o.nx = pt_x; o.ny = pt_y; o.peak = peak; o.total = iters;
		return o;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] e,
			input logic [63:0] a);
		if (e !== a) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
		end
	endfunction

	// monitor: prediction on request acceptance, compare on response, watchdog
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				request_t r;
				r.cmd = cmd_t'(req_ch.command);
				r.sx = req_ch.start_x; r.sy = req_ch.start_y;
				r.rc = req_ch.read_col; r.rr = req_ch.read_row;
				outcome_q.push_back(advance(r));
				req_took = 1;
				n_taken++;
				idle_cycles = 0;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				idle_cycles = 0;
				if (outcome_q.size() == 0) begin
					errors++;
					$display("%0t: response with nothing expected", $time);
				end else begin
					e = outcome_q.pop_front();
					check_field("new_x", e.nx, $unsigned(rsp_ch.new_x));
					check_field("new_y", e.ny, $unsigned(rsp_ch.new_y));
					check_field("hit", e.hit, rsp_ch.hit);
					check_field("pixel_col", e.col, rsp_ch.pixel_col);
					check_field("pixel_row", e.row, rsp_ch.pixel_row);
					check_field("cell_count", e.cnt_val, rsp_ch.cell_count);
					check_field("max_count", e.peak, rsp_ch.max_count);
					check_field("total_iterations", e.total, rsp_ch.total_iterations);
				end
			end
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// request driver: holds a request until taken, random gap bursts
	always @(negedge clk) begin
		request_t r;
		if (!req_ch.valid || req_took) begin
			req_took = 0;
			if (gap_cnt > 0) begin
				gap_cnt--;
				req_ch.valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				r = pending_q.pop_front();
				req_ch.valid    <= 1'b1;
				req_ch.command  <= r.cmd;
				req_ch.start_x  <= r.sx;
				req_ch.start_y  <= r.sy;
				req_ch.read_col <= r.rc;
				req_ch.read_row <= r.rr;
				if (!quiet && $urandom_range(0, 7) == 0) gap_cnt = $urandom_range(1, 17);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response sink: random stall bursts plus one long hold-off
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1;
			hold_cnt = 1500;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			rsp_ch.ready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 9) == 0) stall_cnt = $urandom_range(1, 17);
		end
	end

	task automatic push(input cmd_t c, input int sx, input int sy, input int rc, input int rr);
		request_t r;
		r.cmd = c; r.sx = sx[18:0]; r.sy = sy[18:0]; r.rc = rc[7:0]; r.rr = rr[7:0];
		pending_q.push_back(r);
		n_pushed++;
	endtask

	task automatic push_rand_start();
		push(CMD_CLEAR, $urandom_range(0, 524287), $urandom_range(0, 524287), 0, 0);
	endtask

	// read a cell that was plotted, or any cell
	task automatic push_read();
		int key;
		if (hit_cells.size() != 0 && $urandom_range(0, 2) != 0)
			key = hit_cells[$urandom_range(0, hit_cells.size() - 1)];
		else
			key = $urandom_range(0, 65535);
		push(CMD_READ, $urandom_range(0, 524287), $urandom_range(0, 524287),
			key % 256, key / 256);
	endtask

	// wait for all requests to be taken and all responses checked, then settle
	task automatic drain();
		while (n_taken != n_pushed || outcome_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input int value);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1;
		paddr = CFG_AW'(4 * int'(idx));
		pwdata = value;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
		case (idx)
			REG_COEF_A:     k_a = value[20:0];
			REG_COEF_B:     k_b = value[20:0];
			REG_COEF_C:     k_c = value[20:0];
			REG_COEF_D:     k_d = value[20:0];
			REG_PLOT_SCALE: k_scale = value[23:0];
			REG_OFFSET_X:   k_offx = value[18:0];
			REG_OFFSET_Y:   k_offy = value[18:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input int a, input int b, input int c, input int d,
			input int sc, input int ox, input int oy);
		reg_write(REG_COEF_A, a);
		reg_write(REG_COEF_B, b);
		reg_write(REG_COEF_C, c);
		reg_write(REG_COEF_D, d);
		reg_write(REG_PLOT_SCALE, sc);
		reg_write(REG_OFFSET_X, ox);
		reg_write(REG_OFFSET_Y, oy);
	endtask

	// mostly iterations, with reads, a rare clear and the unused command
	task automatic random_mix(input int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) push(CMD_ITER, $urandom_range(0, 524287), $urandom_range(0, 524287),
				$urandom_range(0, 255), $urandom_range(0, 255));
			else if (pick < 92) push_read();
			else if (pick < 93) push_rand_start();
			else push(CMD_NONE, $urandom_range(0, 524287), $urandom_range(0, 524287),
				$urandom_range(0, 255), $urandom_range(0, 255));
		end
	endtask

	initial begin
		req_ch.valid = 0; req_ch.command = CMD_ITER;
		req_ch.start_x = '0; req_ch.start_y = '0;
		req_ch.read_col = '0; req_ch.read_row = '0;
		rsp_ch.ready = 0;
		k_a = 21'sd93004; k_b = -21'sd149693; k_c = 21'sd159091; k_d = -21'sd142685;
		k_scale = 24'd13107; k_offx = '0; k_offy = '0;
		pt_x = '0; pt_y = '0; peak = '0; iters = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed, reset values of the registers
		push(CMD_ITER, 0, 0, 0, 0);
		push(CMD_ITER, 0, 0, 0, 0);
		push(CMD_READ, 0, 0, 0, 0);
		push(CMD_READ, 0, 0, 255, 255);
		push(CMD_NONE, 0, 0, 0, 0);
		push(CMD_CLEAR, 0, 0, 0, 0);
		repeat (6) push(CMD_ITER, 0, 0, 0, 0);
		push(CMD_READ, 0, 0, 128, 128);
		push(CMD_CLEAR, -262144, 262143, 0, 0);
		repeat (4) push(CMD_ITER, 0, 0, 0, 0);
		push(CMD_CLEAR, 262143, -262144, 0, 0);
		repeat (3) push(CMD_ITER, 0, 0, 0, 0);
		push_read();
		push(CMD_NONE, -1, -1, 255, 255);
		drain();

		// extremes: large coefficients, largest scale, negative offsets; long hold-off
		set_all(655360, -655360, -655360, 655360, 16777215, -131072, -131072);
		hold_req = 1;
		push(CMD_ITER, 0, 0, 0, 0);
		random_mix(40);
		drain();

		// other extremes: zero scale lands every point at the grid centre
		set_all(-655360, 655360, 655360, -655360, 0, 131072, 131072);
		repeat (20) push(CMD_ITER, 0, 0, 0, 0);
		push(CMD_READ, 0, 0, 128, 128);
		drain();

		// random settings around a visible view
		for (int ph = 0; ph < 5; ph++) begin
			set_all(int'($urandom_range(0, 1310720)) - 655360,
				int'($urandom_range(0, 1310720)) - 655360,
				int'($urandom_range(0, 1310720)) - 655360,
				int'($urandom_range(0, 1310720)) - 655360,
				(ph == 0) ? $urandom_range(0, 16777215) : $urandom_range(4000, 30000),
				int'($urandom_range(0, 262144)) - 131072,
				int'($urandom_range(0, 65536)) - 32768);
			if ($urandom_range(0, 1)) push_rand_start();
			random_mix(80);
			drain();
		end

		// last stretch at full rate, default attractor
		quiet = 1;
		set_all(93004, -149693, 159091, -142685, 13107, 0, 0);
		random_mix(60);
		drain();

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
src/adu_pkg.sv
src/adu_if.sv
src/adu_front.sv
src/adu_sincos.sv
src/adu_back.sv
src/attractor_density_accumulator_unit.sv
tb/tb_attractor_density_accumulator_unit.sv
